>>> rtl/nud_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nud_pkg
// Shared constants, token type and bit helpers for the nested UTF-8 decoder.
// ----------------------------------------------------------------------------
package nud_pkg;

    localparam int BYTE_W     = 8;
    localparam int BUF_W      = 64;
    localparam int CODE_W     = 42;
    localparam int REM_W      = 4;
    localparam int CFG_W      = 3;
    localparam int MAX_LEVELS = 4;
    localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
    localparam int LZ_W       = $clog2(BUF_W);
    localparam int M_TDATA_W  = ((CODE_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] DECODE_LEVELS_RST = CFG_W'(4);
    localparam logic [LVL_W-1:0] LEVELS_SAT        = LVL_W'(MAX_LEVELS);

    // one sequence as it travels down the row of level cells
    typedef struct packed {
        logic [BUF_W-1:0] value;
        logic             err;
        logic [LVL_W-1:0] cnt;
    } t_token;

    // count of leading ones in a byte, 0..8
    function automatic logic [REM_W-1:0] lead_ones8(input logic [BYTE_W-1:0] b);
        logic [REM_W-1:0] n;
        logic             stop;
        n    = '0;
        stop = 1'b0;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (!stop) begin
                if (b[i]) begin
                    n = n + REM_W'(1);
                end else begin
                    stop = 1'b1;
                end
            end
        end
        return n;
    endfunction

    // count of leading zeros of a nonzero word
    function automatic logic [LZ_W-1:0] lzc64(input logic [BUF_W-1:0] v);
        logic [LZ_W-1:0] lz;
        logic            found;
        lz    = '0;
        found = 1'b0;
        for (int i = BUF_W - 1; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) begin
                    found = 1'b1;
                end else begin
                    lz = lz + LZ_W'(1);
                end
            end
        end
        return lz;
    endfunction

    // gather the payload bits of a normalized word whose top byte has n lead ones
    function automatic logic [CODE_W-1:0] gather(input logic [BUF_W-1:0] w,
                                                 input logic [REM_W-1:0] n);
        logic [CODE_W-1:0] r;
        logic [BYTE_W-1:0] lead;
        lead = w[BUF_W-1 -: BYTE_W] & (8'hFF >> n);
        r    = CODE_W'(lead);
        for (int g = 1; g < BYTE_W; g++) begin
            if (REM_W'(g) < n) begin
                r = {r[CODE_W-7:0], w[BUF_W-3-BYTE_W*g -: 6]};
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/nested_utf8_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_utf8_decoder
// Frames a byte stream into UTF-8-style sequences and decodes each one up to
// MAX_LEVELS times through a row of level cells.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while s_axis_tready is high. A sequence ends
// on its last byte and its result then passes through the framer register
// and, in each level cell, a register after the leading zero strip and one
// after the bit gather. Every cell is always in the path; decode_levels only
// sets how many cells act on the value. Bytes that do not end a sequence
// give no output transfer. Backpressure on the output stalls the row one
// stage at a time, so bytes keep flowing until the stages between the
// framer and the output are full. decode_levels is written through
// i_cfg_we/i_cfg_wdata while the block is idle, a rule for the user that
// the block does not enforce; values above MAX_LEVELS act as MAX_LEVELS.
// ----------------------------------------------------------------------------
module nested_utf8_decoder
    import nud_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,    // decode_levels
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] in_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [41:0] code_value, rest zero
    output logic                 m_axis_tuser    // [0] zero_error
);

    logic [CFG_W-1:0] r_decode_levels;
    logic             v   [MAX_LEVELS+1];
    logic             rdy [MAX_LEVELS+1];
    t_token           tok [MAX_LEVELS+1];

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_levels <= DECODE_LEVELS_RST;
        end else if (i_cfg_we) begin
            r_decode_levels <= i_cfg_wdata;
        end
    end

    // sequence framing
    nud_framer u_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_levels (r_decode_levels),
        .o_valid  (v[0]),
        .i_ready  (rdy[0]),
        .o_token  (tok[0])
    );

    // row of decode level cells
    for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
        nud_level_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[k]),
            .o_ready (rdy[k]),
            .i_token (tok[k]),
            .o_valid (v[k+1]),
            .i_ready (rdy[k+1]),
            .o_token (tok[k+1])
        );
    end

    // output transfer
    assign rdy[MAX_LEVELS] = m_axis_tready;
    assign m_axis_tvalid   = v[MAX_LEVELS];
    assign m_axis_tuser    = tok[MAX_LEVELS].err;
    assign m_axis_tdata    = tok[MAX_LEVELS].err
                             ? '0
                             : M_TDATA_W'(tok[MAX_LEVELS].value[CODE_W-1:0]);

endmodule

>>> rtl/nud_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nud_framer
// Collects stream bytes into sequences by the lead byte's count of leading
// ones and hands each completed sequence on as a token.
// ----------------------------------------------------------------------------
module nud_framer
    import nud_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [CFG_W-1:0]  i_levels,
    output logic              o_valid,
    input  logic              i_ready,
    output t_token            o_token
);

    logic [BUF_W-1:0] r_buf, n_buf;
    logic [REM_W-1:0] r_rem, n_rem;
    logic             r_valid;
    t_token           r_token, n_token;
    logic             acc;
    logic             done;
    logic [REM_W-1:0] lead_n;
    logic [REM_W-1:0] rem_cur;
    logic [BUF_W-1:0] sum;

    assign o_ready = !r_valid || i_ready;
    assign acc     = i_valid && o_ready;

    // frame the incoming byte
    always_comb begin
        lead_n = lead_ones8(i_byte);
        if (r_rem == '0) begin
            rem_cur = (lead_n == '0) ? REM_W'(1) : lead_n;
            sum     = BUF_W'(i_byte);
        end else begin
            rem_cur = r_rem;
            sum     = r_buf | BUF_W'(i_byte);
        end
        n_rem = rem_cur - REM_W'(1);
        done  = (n_rem == '0);
        n_buf = done ? sum : (sum << BYTE_W);
        n_token.value = sum;
        n_token.err   = 1'b0;
        n_token.cnt   = ({1'b0, i_levels} > REM_W'(MAX_LEVELS)) ? LEVELS_SAT
                                                                 : LVL_W'(i_levels);
    end

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_rem <= '0;
        end else if (acc) begin
            r_buf <= n_buf;
            r_rem <= n_rem;
        end
    end

    // token register toward the first level cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= acc && done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && done) begin
            r_token <= n_token;
        end
    end

    assign o_valid = r_valid;
    assign o_token = r_token;

`ifndef NO_ASSERTIONS
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= REM_W'(8))
        else $error("remaining byte count out of range");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && r_rem == REM_W'(1) |=> r_valid)
        else $error("last byte of a sequence gave no token");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_token))
        else $error("stalled token changed");
`endif

endmodule

>>> rtl/nud_level_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nud_level_cell
// One decode level: a normalize stage (leading zero strip) and a gather stage
// (lead-one count and payload bit collection), each with its own register.
// ----------------------------------------------------------------------------
module nud_level_cell
    import nud_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_token i_token,
    output logic   o_valid,
    input  logic   i_ready,
    output t_token o_token
);

    logic   r_v1, r_v2;
    logic   r_act1, n_act1;
    t_token r_t1, n_t1;
    t_token r_t2, n_t2;
    logic   s2_rdy;

    assign s2_rdy  = !r_v2 || i_ready;
    assign o_ready = !r_v1 || s2_rdy;

    // normalize: flag a zero value, else shift out the leading zeros
    always_comb begin
        n_t1   = i_token;
        n_act1 = (i_token.cnt != '0) && !i_token.err;
        if (n_act1 && i_token.value == '0) begin
            n_t1.err = 1'b1;
            n_act1   = 1'b0;
        end
        if (n_act1) begin
            n_t1.value = i_token.value << lzc64(i_token.value);
        end
    end

    // gather the payload bits into the next level's value
    always_comb begin
        n_t2 = r_t1;
        if (r_act1) begin
            n_t2.value = BUF_W'(gather(r_t1.value, lead_ones8(r_t1.value[BUF_W-1 -: BYTE_W])));
            n_t2.cnt   = r_t1.cnt - LVL_W'(1);
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (s2_rdy) begin
                r_v2 <= r_v1;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_t1   <= n_t1;
            r_act1 <= n_act1;
        end
        if (s2_rdy && r_v1) begin
            r_t2 <= n_t2;
        end
    end

    assign o_valid = r_v2;
    assign o_token = r_t2;

`ifndef NO_ASSERTIONS
    a_err_clears_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_t1.err |-> !r_act1)
        else $error("level active on an errored token");

    a_act_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_act1 |-> r_t1.value[BUF_W-1])
        else $error("normalized value lacks its top bit");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_act1 && s2_rdy |=> r_t2.cnt == $past(r_t1.cnt) - LVL_W'(1))
        else $error("level count not decremented");
`endif

endmodule
